// ===== src/rcbh_pkg.sv =====
// shared types, codes and constants of the rc receiver bind and hop control
`timescale 1ns / 1ps

package rcbh_pkg;

    // widths of the fields
    localparam int ADDR_W = 40;
    localparam int TIME_W = 32;
    localparam int CHAN_W = 7;
    localparam int BYTE_W = 8;
    localparam int LOW_W  = 5;

    // default number of hop channels, at most the size of the base table
    localparam int HOP_CHANNELS_DEF = 4;
    localparam int HOP_BASE_N       = 4;

    // action codes on the input tuser
    localparam logic [1:0] ACT_POLL    = 2'd0;
    localparam logic [1:0] ACT_PACKET  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // kind codes on the output tuser
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BIND = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_IDENTITY = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_BIND_CH  = 2'd2;

    // reset values
    localparam logic [ADDR_W-1:0] RESET_IDENTITY = '0;
    localparam logic [TIME_W-1:0] RESET_TIMEOUT  = 32'd5000;
    localparam logic [CHAN_W-1:0] RESET_BIND_CH  = 7'd76;
    localparam logic [ADDR_W-1:0] DEFAULT_ADDR   = 40'h8f7e6d5c4b;

    // bind packet magic pair
    localparam logic [BYTE_W-1:0] MAGIC_FIRST  = 8'hae;
    localparam logic [BYTE_W-1:0] MAGIC_SECOND = 8'hc9;

    // hop channel bases, entry 0 in the low bits
    localparam logic [HOP_BASE_N-1:0][CHAN_W-1:0] HOP_BASE =
        {7'h10, 7'h31, 7'h42, 7'h59};

    typedef struct packed {
        logic [ADDR_W-1:0] identity;
        logic [TIME_W-1:0] timeout;
        logic [CHAN_W-1:0] bind_ch;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] now_us;
        logic [BYTE_W-1:0] magic_first;
        logic [BYTE_W-1:0] magic_second;
        logic [ADDR_W-1:0] offered_address;
    } item_t;

    typedef struct packed {
        logic [1:0]        received_kind;
        logic [CHAN_W-1:0] tune_channel;
        logic              tune_now;
        logic              address_write;
        logic [ADDR_W-1:0] listen_address;
        logic              is_bound;
    } result_t;

    // hop channel of one table entry for a given address low part
    function automatic logic [CHAN_W-1:0] hop_chan(input logic [1:0] idx,
                                                   input logic [LOW_W-1:0] low);
        return HOP_BASE[idx] + {2'b00, low};
    endfunction

endpackage

// ===== src/rcbh_cfg_regs.sv =====
// configuration registers of the rc receiver bind and hop control
`timescale 1ns / 1ps

module rcbh_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [rcbh_pkg::ADDR_W-1:0]   cfg_data,
    output rcbh_pkg::cfg_t                cfg
);

    rcbh_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.identity <= rcbh_pkg::RESET_IDENTITY;
            cfg_reg.timeout  <= rcbh_pkg::RESET_TIMEOUT;
            cfg_reg.bind_ch  <= rcbh_pkg::RESET_BIND_CH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcbh_pkg::REG_IDENTITY: cfg_reg.identity <= cfg_data;
                rcbh_pkg::REG_TIMEOUT:  cfg_reg.timeout  <= cfg_data[rcbh_pkg::TIME_W-1:0];
                rcbh_pkg::REG_BIND_CH:  cfg_reg.bind_ch  <= cfg_data[rcbh_pkg::CHAN_W-1:0];
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rcbh_link_ctrl.sv =====
// link state, hop table and per-word decision logic
`timescale 1ns / 1ps

module rcbh_link_ctrl
#(
    parameter int HOP_CHANNELS = rcbh_pkg::HOP_CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  rcbh_pkg::item_t   item,
    input  rcbh_pkg::cfg_t    cfg,
    output rcbh_pkg::result_t res
);

    localparam int IDX_W = (HOP_CHANNELS > 1) ? $clog2(HOP_CHANNELS) : 1;
    localparam logic [IDX_W:0] HOP_LAST = (IDX_W + 1)'(HOP_CHANNELS);

    logic                              phase_reg, phase_next;
    logic [rcbh_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [rcbh_pkg::CHAN_W-1:0]       table_reg  [HOP_CHANNELS];
    logic [rcbh_pkg::CHAN_W-1:0]       table_next [HOP_CHANNELS];
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [rcbh_pkg::TIME_W-1:0]       last_reg, last_next;

    logic [rcbh_pkg::TIME_W-1:0]       limit;
    logic                              timed_out;
    logic [IDX_W:0]                    idx_inc;
    logic [IDX_W-1:0]                  idx_step;
    logic                              magic_ok;
    logic                              enter;
    logic [rcbh_pkg::LOW_W-1:0]        enter_low;

    // hop timer and index step
    assign limit     = last_reg + cfg.timeout;
    assign timed_out = item.now_us > limit;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign idx_step  = (idx_inc >= HOP_LAST) ? '0 : idx_inc[IDX_W-1:0];
    assign magic_ok  = (item.magic_first == rcbh_pkg::MAGIC_FIRST)
                    && (item.magic_second == rcbh_pkg::MAGIC_SECOND);

    // next state and result of one word
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        enter      = 1'b0;
        enter_low  = '0;
        res        = '0;
        for (int i = 0; i < HOP_CHANNELS; i++)
        begin
            table_next[i] = table_reg[i];
        end

        case (item.action)
            rcbh_pkg::ACT_RESTART:
            begin
                res.address_write = 1'b1;
                res.tune_now      = 1'b1;
                if (cfg.identity == '0)
                begin
                    phase_next       = 1'b0;
                    res.tune_channel = cfg.bind_ch;
                end
                else
                begin
                    addr_next        = cfg.identity;
                    enter            = 1'b1;
                    enter_low        = cfg.identity[rcbh_pkg::LOW_W-1:0];
                    res.tune_channel = rcbh_pkg::hop_chan(2'd0, enter_low);
                end
            end
            default:
            begin
                if (!phase_reg)
                begin
                    // bind state: wait for the magic pair
                    if (item.action == rcbh_pkg::ACT_PACKET && magic_ok)
                    begin
                        res.received_kind = rcbh_pkg::KIND_BIND;
                        addr_next         = item.offered_address;
                        enter             = 1'b1;
                        enter_low         = item.offered_address[rcbh_pkg::LOW_W-1:0];
                        res.tune_channel  = rcbh_pkg::hop_chan(2'd0, enter_low);
                        res.tune_now      = 1'b1;
                        res.address_write = 1'b1;
                    end
                end
                else
                begin
                    // data state: hop on a packet or on timeout
                    if (item.action == rcbh_pkg::ACT_PACKET)
                    begin
                        res.received_kind = rcbh_pkg::KIND_DATA;
                    end
                    if (item.action == rcbh_pkg::ACT_PACKET || timed_out)
                    begin
                        idx_next         = idx_step;
                        res.tune_channel = table_reg[idx_step];
                        res.tune_now     = 1'b1;
                        last_next        = item.now_us;
                    end
                end
            end
        endcase

        // entering the data state rebuilds the hop table
        if (enter)
        begin
            phase_next = 1'b1;
            idx_next   = '0;
            last_next  = item.now_us;
            for (int i = 0; i < HOP_CHANNELS; i++)
            begin
                table_next[i] = rcbh_pkg::hop_chan(2'(i), enter_low);
            end
        end

        res.listen_address = addr_next;
        res.is_bound       = phase_next;
    end

    // link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            addr_reg  <= rcbh_pkg::DEFAULT_ADDR;
            idx_reg   <= '0;
            last_reg  <= '0;
            for (int i = 0; i < HOP_CHANNELS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            for (int i = 0; i < HOP_CHANNELS; i++)
            begin
                table_reg[i] <= table_next[i];
            end
        end
    end

endmodule

// ===== src/rc_receiver_bind_and_hop_control.sv =====
// top level of the rc receiver bind and hop control
//
// usage
//   s_axis carries one event word per handshake: tuser holds the action
//   (poll, packet, restart), tdata the time stamp and packet bytes.
//   m_axis returns exactly one result word per event word, in order:
//   tuser holds the received kind, tdata the tuning and address outputs.
//   cfg_we/cfg_index/cfg_data write the identity, hop timeout and bind
//   channel registers; write them only while no word is in flight.
// timing
//   the result word passes the input register, then the decision logic
//   into the result register, where it waits while m_axis_tready is low.
//   throughput is one word per cycle while m_axis_tready is high, set by the single decision stage.
// reset
//   rst_n clears both pipeline stages, loads the register defaults and
//   puts the link into bind state with the default bind address.
// back-pressure
//   when m_axis_tready is low the result register holds its word; the
//   input register still takes one more word, then s_axis_tready drops.
`timescale 1ns / 1ps

module rc_receiver_bind_and_hop_control
#(
    parameter int HOP_CHANNELS = rcbh_pkg::HOP_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // event words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // now_us, magic_first, magic_second, offered_address
    input  logic [1:0]  s_axis_tuser,  // action
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // tune_channel, tune_now, address_write,
                                       // listen_address, is_bound, zero fill
    output logic [1:0]  m_axis_tuser,  // received_kind
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    logic              in_valid_reg;
    rcbh_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    rcbh_pkg::result_t out_res_reg;

    rcbh_pkg::cfg_t    cfg;
    rcbh_pkg::result_t res;
    logic              advance;

    // configuration registers
    rcbh_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // link decision logic and state
    rcbh_link_ctrl #(
        .HOP_CHANNELS (HOP_CHANNELS)
    ) u_link_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // pipeline flow control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.action          <= s_axis_tuser;
            in_item_reg.now_us          <= s_axis_tdata[31:0];
            in_item_reg.magic_first     <= s_axis_tdata[39:32];
            in_item_reg.magic_second    <= s_axis_tdata[47:40];
            in_item_reg.offered_address <= s_axis_tdata[87:48];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.received_kind;
    assign m_axis_tdata  = {6'b000000,
                            out_res_reg.is_bound,
                            out_res_reg.listen_address,
                            out_res_reg.address_write,
                            out_res_reg.tune_now,
                            out_res_reg.tune_channel};

    // no channel is shown unless a tune is requested
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_res_reg.tune_now) |-> (out_res_reg.tune_channel == '0))
        else $error("tune channel set without tune request");

    // an address write always comes with a retune
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.address_write) |-> out_res_reg.tune_now)
        else $error("address write without retune");

    // data packets are reported only in data state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.received_kind == rcbh_pkg::KIND_DATA)
        |-> out_res_reg.is_bound)
        else $error("data packet reported in bind state");

    // a bind packet always lands in data state with a new address written
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.received_kind == rcbh_pkg::KIND_BIND)
        |-> (out_res_reg.is_bound && out_res_reg.address_write))
        else $error("bind packet without entering data state");

    // input side stalls only when both stages are full and the output waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

endmodule
